[rtl/trie_prefix_free_checker_unit_assert.svh]
// Assertion macros for the trie prefix-free checker.
// Used by the top level only; the macros expect clk and rst_n in scope.
`ifndef TRIE_PREFIX_FREE_CHECKER_UNIT_ASSERT_SVH
`define TRIE_PREFIX_FREE_CHECKER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TPF_ASSERT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("trie checker assertion failed");

// Next-cycle implication, checked outside reset.
`define TPF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("trie checker assertion failed");

`endif

[rtl/tpf_pkg.sv]
// Shared types and constants of the trie prefix-free checker.
// No dependencies; used by the input channel interface, the top level and the testbench.
package tpf_pkg;

    localparam int NODES_DEF    = 1024;
    localparam int ALPHABET_DEF = 26;
    localparam int LETTER_W     = 5;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LINK,
        ST_CHILD,
        ST_MARK,
        ST_FINISH
    } tpf_state_t;

endpackage

[rtl/tpf_in_if.sv]
// Input channel of the trie prefix-free checker: one letter or clear per item.
// Depends on tpf_pkg for the letter width.
interface tpf_in_if
    import tpf_pkg::*;
;
    logic                valid;
    logic                ready;
    logic                op;
    logic [LETTER_W-1:0] letter;
    logic                word_end;

    modport source (output valid, output op, output letter, output word_end, input ready);
    modport sink   (input valid, input op, input letter, input word_end, output ready);
endinterface

[rtl/tpf_out_if.sv]
// Result channel of the trie prefix-free checker: the two sticky flags.
// No dependencies.
interface tpf_out_if;
    logic valid;
    logic ready;
    logic prefix_found;
    logic pool_full;

    modport source (output valid, output prefix_found, output pool_full, input ready);
    modport sink   (input valid, input prefix_found, input pool_full, output ready);
endinterface

[rtl/trie_prefix_free_checker_unit.sv]
// Trie prefix-free checker: top level.
// Depends on tpf_pkg, tpf_in_if, tpf_out_if and the assertion macro header.
//
// Use: in_ch carries one item per letter (op, letter, word_end) or a clear
// (op set). out_ch returns exactly one item per input item: the sticky
// prefix_found and pool_full flags as they stand after that item.
// The trie lives in one synchronous node table of NODES rows; each row holds
// ALPHABET child links plus the end-of-word and has-children marks.
// Steps per item: an ignored letter (pool full or letter outside the alphabet)
// goes straight to the result. Any other letter reads the current row; a letter
// that follows an existing link then reads the child row and, if it ends the
// word, marks it; a letter that creates a node writes the new link back and, if
// it ends the word, marks the new node; a letter that finds the pool exhausted
// sets pool_full. A clear runs the sweep below. The table has one read port, and
// the block takes no new item until the result of the last one is registered.
// After reset the block sweeps the table, one row a cycle, with in_ch.ready
// low. A clear item runs the same sweep.
// A finished result sits in an output register; if the receiver stalls, the
// block holds the next result until the register frees, and in_ch.ready stays
// low meanwhile.
`include "trie_prefix_free_checker_unit_assert.svh"

module trie_prefix_free_checker_unit
    import tpf_pkg::*;
#(
    parameter int NODES    = NODES_DEF,
    parameter int ALPHABET = ALPHABET_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    tpf_in_if.sink    in_ch,
    tpf_out_if.source out_ch
);

    localparam int NW = $clog2(NODES);
    localparam int LW = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;

    typedef logic [ALPHABET-1:0][NW-1:0] link_row_t;
    typedef struct packed {
        logic      word_end;
        logic      has_ch;
        link_row_t links;
    } node_row_t;

    node_row_t mem [NODES];

    tpf_state_t state_reg, state_next;

    logic [NW-1:0]   clr_addr_reg, clr_addr_next;
    logic            clr_reply_reg, clr_reply_next;
    logic [NW-1:0]   cur_node_reg, cur_node_next;
    logic [NW:0]     next_free_reg, next_free_next;
    logic            found_reg, found_next;
    logic            full_reg, full_next;
    logic [LW-1:0]   letter_idx_reg, letter_idx_next;
    logic            last_reg, last_next;
    logic [NW-1:0]   child_reg, child_next;
    node_row_t       rd_row_reg;
    logic            out_valid_reg, out_valid_next;
    logic            out_found_reg, out_found_next;
    logic            out_full_reg, out_full_next;

    logic            accept;
    logic [LW+LETTER_W-1:0] letter_wide;
    logic            letter_ok;
    logic            clr_done;
    logic            pool_empty;
    logic            out_free;
    logic [NW-1:0]   link;
    logic [NW-1:0]   rd_addr;
    logic            mem_we;
    logic [NW-1:0]   wr_addr;
    node_row_t       wr_row;

    assign letter_wide = {{LW{1'b0}}, in_ch.letter};
    assign letter_ok   = letter_wide < (LW+LETTER_W)'(ALPHABET);
    assign accept      = in_ch.valid && in_ch.ready;
    assign clr_done    = clr_addr_reg == NW'(NODES - 1);
    assign pool_empty  = next_free_reg == (NW+1)'(NODES);
    assign out_free    = !out_valid_reg || out_ch.ready;
    assign link        = rd_row_reg.links[letter_idx_reg];

    assign in_ch.ready         = state_reg == ST_IDLE;
    assign out_ch.valid        = out_valid_reg;
    assign out_ch.prefix_found = out_found_reg;
    assign out_ch.pool_full    = out_full_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_done)
                begin
                    state_next = clr_reply_reg ? ST_FINISH : ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_ch.op == OP_CLEAR)
                    begin
                        state_next = ST_CLEAR;
                    end
                    else if (full_reg || !letter_ok)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_LINK;
                    end
                end
            end
            ST_LINK:
            begin
                if (link != '0)
                begin
                    state_next = ST_CHILD;
                end
                else if (!pool_empty && last_reg)
                begin
                    state_next = ST_MARK;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_CHILD:  state_next = ST_FINISH;
            ST_MARK:   state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // Datapath, table access and result register.
    always_comb
    begin
        clr_addr_next   = clr_addr_reg;
        clr_reply_next  = clr_reply_reg;
        cur_node_next   = cur_node_reg;
        next_free_next  = next_free_reg;
        found_next      = found_reg;
        full_next       = full_reg;
        letter_idx_next = letter_idx_reg;
        last_next       = last_reg;
        child_next      = child_reg;
        out_valid_next  = out_valid_reg && !out_ch.ready;
        out_found_next  = out_found_reg;
        out_full_next   = out_full_reg;
        rd_addr         = cur_node_reg;
        mem_we          = 1'b0;
        wr_addr         = cur_node_reg;
        wr_row          = rd_row_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we        = 1'b1;
                wr_addr       = clr_addr_reg;
                wr_row        = '0;
                clr_addr_next = clr_addr_reg + NW'(1);
                if (clr_done)
                begin
                    clr_addr_next = '0;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    letter_idx_next = letter_wide[LW-1:0];
                    last_next       = in_ch.word_end;
                    clr_reply_next  = in_ch.op == OP_CLEAR;
                    if (in_ch.op == OP_CLEAR)
                    begin
                        clr_addr_next  = '0;
                        cur_node_next  = '0;
                        next_free_next = (NW+1)'(1);
                        found_next     = 1'b0;
                        full_next      = 1'b0;
                    end
                end
            end
            ST_LINK:
            begin
                if (link != '0)
                begin
                    // Follow the existing edge; the child row arrives next cycle.
                    child_next = link;
                    rd_addr    = link;
                end
                else if (pool_empty)
                begin
                    full_next = 1'b1;
                end
                else
                begin
                    // A fresh node's row was swept to zero, so it ends no word
                    // and has no children.
                    child_next     = next_free_reg[NW-1:0];
                    next_free_next = next_free_reg + (NW+1)'(1);
                    mem_we         = 1'b1;
                    wr_addr        = cur_node_reg;
                    wr_row.links[letter_idx_reg] = next_free_reg[NW-1:0];
                    wr_row.has_ch  = 1'b1;
                    cur_node_next  = last_reg ? '0 : next_free_reg[NW-1:0];
                end
            end
            ST_CHILD:
            begin
                if (rd_row_reg.word_end || (last_reg && rd_row_reg.has_ch))
                begin
                    found_next = 1'b1;
                end
                mem_we          = last_reg;
                wr_addr         = child_reg;
                wr_row.word_end = 1'b1;
                cur_node_next   = last_reg ? '0 : child_reg;
            end
            ST_MARK:
            begin
                mem_we          = 1'b1;
                wr_addr         = child_reg;
                wr_row          = '0;
                wr_row.word_end = 1'b1;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_found_next = found_reg;
                    out_full_next  = full_reg;
                end
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Node table: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= wr_row;
        end
        rd_row_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            clr_reply_reg <= 1'b0;
            cur_node_reg  <= '0;
            next_free_reg <= (NW+1)'(1);
            found_reg     <= 1'b0;
            full_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            clr_reply_reg <= clr_reply_next;
            cur_node_reg  <= cur_node_next;
            next_free_reg <= next_free_next;
            found_reg     <= found_next;
            full_reg      <= full_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        letter_idx_reg <= letter_idx_next;
        last_reg       <= last_next;
        child_reg      <= child_next;
        out_found_reg  <= out_found_next;
        out_full_reg   <= out_full_next;
    end

    // The walk only ever stands on a node that has been handed out.
    `TPF_ASSERT(a_cur_allocated, 1'b1, {1'b0, cur_node_reg} < next_free_reg)
    // Following an edge reads the child while the current row is not written.
    `TPF_ASSERT(a_no_rw_clash, state_reg == ST_LINK && link != '0, !mem_we)
    // Any sweep of the table runs with both flags down.
    `TPF_ASSERT(a_clear_flags, state_reg == ST_CLEAR, !found_reg && !full_reg)
    // A finished item with a free output register shows its result next cycle.
    `TPF_ASSERT_NEXT(a_finish_out, state_reg == ST_FINISH && !out_valid_reg, out_valid_reg)

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for trie_prefix_free_checker_unit: a directed table, then random
// words, noise, clears and a run that fills the node pool. Depends on tpf_pkg and the channels.
module testbench;
    import tpf_pkg::*;

    localparam int LIMIT_CYCLES = 600000;
    localparam int ITEM_TARGET  = 1550;
    localparam int FILL_START   = 350;
    localparam int HOLD_AT      = 120;
    localparam int TAIL_CYCLES  = 16;
    localparam int LETTER_MAX   = (1 << LETTER_W) - 1;

    typedef struct packed {
        logic found;
        logic full;
    } flags_t;

    typedef struct packed {
        logic                op;
        logic [LETTER_W-1:0] ltr;
        logic                wend;
        logic                fixed;
        logic                found;
        logic                full;
    } stim_row_t;

    // Rows marked fixed carry their flags typed in; the others are checked by the predictor.
    localparam int DIRECTED_ROWS = 25;
    localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{OP_CLEAR,   5'd0,  1'b0, 1'b1, 1'b0, 1'b0},
        '{OP_INSERT,  5'd0,  1'b1, 1'b1, 1'b0, 1'b0},
        '{OP_INSERT,  5'd25, 1'b1, 1'b1, 1'b0, 1'b0},
        '{OP_INSERT,  5'd31, 1'b1, 1'b1, 1'b0, 1'b0},
        '{OP_INSERT,  5'd26, 1'b0, 1'b1, 1'b0, 1'b0},
        '{OP_INSERT,  5'd1,  1'b0, 1'b0, 1'b0, 1'b0},
        '{OP_INSERT,  5'd2,  1'b1, 1'b0, 1'b0, 1'b0},
        '{OP_INSERT,  5'd1,  1'b1, 1'b0, 1'b0, 1'b0},
        '{OP_CLEAR,   5'd31, 1'b1, 1'b1, 1'b0, 1'b0},
        '{OP_INSERT,  5'd3,  1'b0, 1'b0, 1'b0, 1'b0},
        '{OP_INSERT,  5'd4,  1'b1, 1'b0, 1'b0, 1'b0},
        '{OP_INSERT,  5'd3,  1'b0, 1'b0, 1'b0, 1'b0},
        '{OP_INSERT,  5'd4,  1'b1, 1'b0, 1'b0, 1'b0},
        '{OP_CLEAR,   5'd0,  1'b0, 1'b1, 1'b0, 1'b0},
        '{OP_INSERT,  5'd5,  1'b1, 1'b0, 1'b0, 1'b0},
        '{OP_INSERT,  5'd5,  1'b0, 1'b0, 1'b0, 1'b0},
        '{OP_INSERT,  5'd6,  1'b1, 1'b0, 1'b0, 1'b0},
        '{OP_CLEAR,   5'd0,  1'b0, 1'b1, 1'b0, 1'b0},
        '{OP_INSERT,  5'd7,  1'b0, 1'b0, 1'b0, 1'b0},
        '{OP_INSERT,  5'd30, 1'b1, 1'b0, 1'b0, 1'b0},
        '{OP_INSERT,  5'd8,  1'b1, 1'b0, 1'b0, 1'b0},
        '{OP_INSERT,  5'd7,  1'b0, 1'b0, 1'b0, 1'b0},
        '{OP_INSERT,  5'd8,  1'b0, 1'b0, 1'b0, 1'b0},
        '{OP_INSERT,  5'd9,  1'b1, 1'b0, 1'b0, 1'b0},
        '{OP_CLEAR,   5'd0,  1'b0, 1'b1, 1'b0, 1'b0}
    };

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    tpf_in_if  in_ch();
    tpf_out_if out_ch();

    trie_prefix_free_checker_unit DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    always #4 clk = ~clk;

    // Predictor copy of the trie.
    logic [9:0]  trie_link [NODES_DEF*ALPHABET_DEF];
    logic        trie_word_end [NODES_DEF];
    logic        trie_has_kids [NODES_DEF];
    logic [9:0]  walk_node;
    logic [10:0] free_node;
    logic        seen_prefix;
    logic        pool_exhausted;

    flags_t flags_due [$];
    int     n_sent = 0;
    int     n_bad = 0;
    int     cycles = 0;
    int     stall_left = 0;
    bit     long_hold_done = 1'b0;
    bit     calm = 1'b0;

    function automatic void trie_clear();
        for (int i = 0; i < NODES_DEF*ALPHABET_DEF; i++)
            trie_link[i] = '0;
        for (int i = 0; i < NODES_DEF; i++)
        begin
            trie_word_end[i] = 1'b0;
            trie_has_kids[i] = 1'b0;
        end
        walk_node      = '0;
        free_node      = 11'd1;
        seen_prefix    = 1'b0;
        pool_exhausted = 1'b0;
    endfunction

    function automatic flags_t next_flags(logic op, logic [LETTER_W-1:0] ltr, logic wend);
        int        slot;
        logic [9:0] kid;
        flags_t    res;
        if (op == OP_CLEAR)
            trie_clear();
        else if (!pool_exhausted && ltr < ALPHABET_DEF)
        begin
            slot = walk_node * ALPHABET_DEF + ltr;
            kid  = trie_link[slot];
            // A missing link with no free node left marks the pool full and drops the letter.
            if (kid == '0 && free_node >= NODES_DEF)
                pool_exhausted = 1'b1;
            else
            begin
                if (kid == '0)
                begin
                    kid = free_node[9:0];
                    free_node = free_node + 11'd1;
                    trie_link[slot] = kid;
                    trie_has_kids[walk_node] = 1'b1;
                end
                walk_node = kid;
                if (trie_word_end[walk_node])
                    seen_prefix = 1'b1;
                if (wend)
                begin
                    if (trie_has_kids[walk_node])
                        seen_prefix = 1'b1;
                    trie_word_end[walk_node] = 1'b1;
                    walk_node = '0;
                end
            end
        end
        res.found = seen_prefix;
        res.full  = pool_exhausted;
        return res;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 20);
    endfunction

    // Called at a rising edge; returns at the edge that accepts the item.
    task automatic send_item(input logic op, input logic [LETTER_W-1:0] ltr, input logic wend,
                             input logic fixed = 1'b0, input flags_t typed = '0);
        int     gap;
        flags_t want;
        if (n_sent % 64 == 0)
            calm = ($urandom_range(0, 3) == 0);
        gap = pick_gap();
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.op       <= op;
        in_ch.letter   <= ltr;
        in_ch.word_end <= wend;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        want = next_flags(op, ltr, wend);
        flags_due.push_back(fixed ? typed : want);
        n_sent++;
    endtask

    task automatic send_word(input int len, input int top_letter);
        logic [LETTER_W-1:0] ltr;
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 29) == 0)
                ltr = LETTER_W'($urandom_range(ALPHABET_DEF, LETTER_MAX));
            else
                ltr = LETTER_W'($urandom_range(0, top_letter));
            send_item(OP_INSERT, ltr, i == len - 1);
        end
    endtask

    task automatic mixed_traffic();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            send_item(OP_INSERT, LETTER_W'($urandom_range(0, LETTER_MAX)),
                      1'($urandom_range(0, 1)));
        else if (r < 11)
            send_item(OP_CLEAR, LETTER_W'($urandom_range(0, LETTER_MAX)),
                      1'($urandom_range(0, 1)));
        else
            send_word($urandom_range(1, 5),
                      ($urandom_range(0, 4) == 0) ? ALPHABET_DEF - 1 : $urandom_range(1, 3));
    endtask

    // The sender stops and waits for every outstanding result.
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (flags_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic check_result();
        flags_t got;
        flags_t want;
        got.found = out_ch.prefix_found;
        got.full  = out_ch.pool_full;
        if (flags_due.size() == 0)
        begin
            $display("%0t: result with nothing outstanding: prefix_found=%b pool_full=%b",
                     $time, got.found, got.full);
            n_bad++;
        end
        else
        begin
            want = flags_due.pop_front();
            if (got.found !== want.found)
            begin
                $display("%0t: prefix_found expected %b, got %b", $time, want.found, got.found);
                n_bad++;
            end
            if (got.full !== want.full)
            begin
                $display("%0t: pool_full expected %b, got %b", $time, want.full, got.full);
                n_bad++;
            end
        end
    endtask

    // Receiver: short and occasional long stalls, plus one long hold-off that backs the
    // block up and forces it to drop in_ch.ready while the sender keeps offering items.
    initial
    begin
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
                check_result();
            if (!rst_n)
                out_ch.ready <= 1'b0;
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end
            else if (!long_hold_done && n_sent >= HOLD_AT)
            begin
                long_hold_done = 1'b1;
                stall_left = 400;
                out_ch.ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                          : $urandom_range(0, 2);
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("%0t: run did not finish within the cycle limit", $time);
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        in_ch.valid    <= 1'b0;
        in_ch.op       <= OP_INSERT;
        in_ch.letter   <= '0;
        in_ch.word_end <= 1'b0;
        trie_clear();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIRECTED_ROWS; i++)
            send_item(DIRECTED[i].op, DIRECTED[i].ltr, DIRECTED[i].wend, DIRECTED[i].fixed,
                      '{found: DIRECTED[i].found, full: DIRECTED[i].full});

        while (n_sent < FILL_START)
        begin
            mixed_traffic();
            if (n_sent >= 200 && n_sent < 210)
                drain();
        end

        // Long words over the whole alphabet until the node pool runs out, then a few
        // items that must all be ignored, a pause for every result, and a clear.
        send_item(OP_CLEAR, '0, 1'b0);
        while (!pool_exhausted)
            send_word($urandom_range(4, 10), ALPHABET_DEF - 1);
        repeat (30)
            send_item(OP_INSERT, LETTER_W'($urandom_range(0, LETTER_MAX)),
                      1'($urandom_range(0, 1)));
        drain();
        send_item(OP_CLEAR, '0, 1'b0);

        while (n_sent < ITEM_TARGET)
            mixed_traffic();

        in_ch.valid <= 1'b0;
        while (flags_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (n_bad == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

[trie_prefix_free_checker_unit.f]
+incdir+rtl
rtl/tpf_pkg.sv
rtl/tpf_in_if.sv
rtl/tpf_out_if.sv
rtl/trie_prefix_free_checker_unit.sv
verif/testbench.sv
